@@ design/xsr_pkg.sv @@
// Shared constants and types of the bounded xorshift64* generator.
`default_nettype none
package xsr_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned HalfW = 32;

	typedef logic [DataW-1:0] word_t;
	typedef logic [2:0]       opcode_t;

	localparam opcode_t OP_SEED       = 3'd0;
	localparam opcode_t OP_NEXT       = 3'd1;
	localparam opcode_t OP_ROLL       = 3'd2;
	localparam opcode_t OP_CHANCE     = 3'd3;
	localparam opcode_t OP_GET_STATE  = 3'd4;
	localparam opcode_t OP_LOAD_STATE = 3'd5;

	localparam word_t GOLDEN_SEED  = 64'h9E37_79B9_7F4A_7C15;
	localparam word_t STAR_MULT    = 64'h2545_F491_4F6C_DD1D;
	localparam word_t STATE_MASK62 = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam word_t CHANCE_BOUND = 64'd100;
	localparam int unsigned SEED_WARMUP = 4;

	localparam int unsigned SHIFT_A = 12;
	localparam int unsigned SHIFT_B = 25;
	localparam int unsigned SHIFT_C = 27;

	function automatic word_t xorshift_step(input word_t s);
		word_t t;
		t = s ^ (s >> SHIFT_A);
		t = t ^ (t << SHIFT_B);
		t = t ^ (t >> SHIFT_C);
		return t;
	endfunction

endpackage
`default_nettype wire

@@ design/xsr_if.sv @@
// Request and response channel interfaces of the generator.
`default_nettype none
interface xsr_req_if import xsr_pkg::*; ();
	logic               valid;
	logic               ready;
	opcode_t            opcode;
	logic signed [63:0] operand_a;
	logic signed [63:0] operand_b;

	modport source (output valid, output opcode, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input opcode, input operand_a, input operand_b,
		output ready);
endinterface

interface xsr_rsp_if import xsr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [63:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

@@ design/xsr_mul.sv @@
// Multi-cycle low-half product of a word and the xorshift64* multiplier.
`default_nettype none
module xsr_mul import xsr_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	input  word_t opd,
	output logic  done,
	output word_t product
);

	word_t            x_q;
	word_t            acc_q;
	logic [1:0]       step_q;
	logic             busy_q;
	logic             done_q;
	logic [HalfW-1:0] mul_a;
	logic [HalfW-1:0] mul_b;
	word_t            pp;

	always_comb begin
		unique case (step_q)
			2'd0: begin
				mul_a = x_q[HalfW-1:0];
				mul_b = STAR_MULT[HalfW-1:0];
			end
			2'd1: begin
				mul_a = x_q[DataW-1:HalfW];
				mul_b = STAR_MULT[HalfW-1:0];
			end
			default: begin
				mul_a = x_q[HalfW-1:0];
				mul_b = STAR_MULT[DataW-1:HalfW];
			end
		endcase
		pp = word_t'(mul_a) * word_t'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= opd;
		end else if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= pp;
			end else begin
				acc_q <= acc_q + {pp[HalfW-1:0], {HalfW{1'b0}}};
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

@@ design/xsr_mod.sv @@
// Radix-2 restoring remainder unit for a positive 63-bit divisor.
`default_nettype none
module xsr_mod import xsr_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  word_t           dividend,
	input  word_t           divisor,
	output logic            done,
	output word_t           rem
);

	word_t             dvd_q;
	logic [DataW-2:0]  dsr_q;
	logic [DataW-2:0]  rem_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	word_t             rem_sh;
	logic [DataW:0]    diff;

	assign rem_sh = {rem_q, dvd_q[DataW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor[DataW-2:0];
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DataW-2:0], 1'b0};
			if (!diff[DataW]) begin
				rem_q <= diff[DataW-2:0];
			end else begin
				rem_q <= rem_sh[DataW-2:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = {1'b0, rem_q};

endmodule
`default_nettype wire

@@ design/xorshift64star_bounded_rng_core.sv @@
// Top level of the bounded xorshift64* generator: sequencer, state and output register.
//
// Usage: one request on req (opcode, operand_a, operand_b) gives exactly one
// response on rsp (value); each moves when valid and ready are high at a clk edge.
// Requests are taken one at a time; req.ready is high only while the sequencer
// is idle. Paths from request accept to the response:
//   get_state, state load, unused opcodes, and next or roll that do not draw:
//   the result and output register stages only
//   seed: four state steps, one a cycle, then the result and output register stages
//   next, roll, chance that draw: one state step, the three-step 32x32 product
//   unit, the one-bit-a-cycle remainder unit, then the result and output register stages
// The remainder unit is the longest step of a drawing request. With no stall the next
// request is taken on the edge that takes the response.
// The response sits in an output register, so a new request is taken while a
// response waits; a finished result then holds in the sequencer until the
// receiver takes the waiting response.
// Reset (arst_n low, asynchronous) loads the golden seed into the state and
// empties the output register.
`default_nettype none
module xorshift64star_bounded_rng_core import xsr_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	xsr_req_if.sink      req,
	xsr_rsp_if.source    rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADV  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_RES  = 3'd4;

	logic [2:0] st_q;
	word_t      gen_state_q;
	opcode_t    op_q;
	word_t      a_q;
	word_t      div_q;
	word_t      res_q;
	logic [1:0] cnt_q;
	logic       out_valid_q;
	word_t      out_value_q;

	word_t      next_state;
	word_t      req_a;
	word_t      req_b;
	word_t      span;
	logic       accept;
	logic       mul_start;
	logic       mul_done;
	word_t      mul_prod;
	logic       mod_start;
	logic       mod_done;
	word_t      mod_rem;
	logic       out_free;

	assign req_a      = req.operand_a;
	assign req_b      = req.operand_b;
	assign span       = req_b - req_a + 64'd1;
	assign next_state = xorshift_step(gen_state_q);
	assign accept     = req.valid && req.ready;
	assign out_free   = !out_valid_q || rsp.ready;
	assign mul_start  = (st_q == ST_ADV) && (op_q != OP_SEED);
	assign mod_start  = (st_q == ST_MUL) && mul_done;

	xsr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.opd     (next_state),
		.done    (mul_done),
		.product (mul_prod)
	);

	xsr_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mul_prod),
		.divisor  (div_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			gen_state_q <= GOLDEN_SEED;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_RES && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.opcode)
							OP_SEED: begin
								gen_state_q <= (req_a != '0) ? req_a : GOLDEN_SEED;
								cnt_q       <= 2'(SEED_WARMUP - 1);
								st_q        <= ST_ADV;
							end
							OP_NEXT: begin
								st_q <= (req_a == '0 || req_a[DataW-1]) ? ST_RES : ST_ADV;
							end
							OP_ROLL: begin
								if ($signed(req_b) <= $signed(req_a) || span == '0
									|| span[DataW-1]) begin
									st_q <= ST_RES;
								end else begin
									st_q <= ST_ADV;
								end
							end
							OP_CHANCE: begin
								st_q <= ST_ADV;
							end
							OP_LOAD_STATE: begin
								gen_state_q <= (req_a != '0) ? req_a : GOLDEN_SEED;
								st_q        <= ST_RES;
							end
							default: begin
								st_q <= ST_RES;
							end
						endcase
					end
				end
				ST_ADV: begin
					gen_state_q <= next_state;
					if (op_q == OP_SEED) begin
						cnt_q <= cnt_q - 2'd1;
						if (cnt_q == '0) begin
							st_q <= ST_RES;
						end
					end else begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						st_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						st_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.opcode;
			a_q  <= req_a;
			unique case (req.opcode)
				OP_NEXT: begin
					div_q <= req_a;
					res_q <= '0;
				end
				OP_ROLL: begin
					div_q <= span;
					res_q <= req_a;
				end
				OP_CHANCE: begin
					div_q <= CHANCE_BOUND;
					res_q <= '0;
				end
				OP_GET_STATE: begin
					div_q <= CHANCE_BOUND;
					res_q <= gen_state_q & STATE_MASK62;
				end
				default: begin
					div_q <= CHANCE_BOUND;
					res_q <= '0;
				end
			endcase
		end else if (st_q == ST_MOD && mod_done) begin
			unique case (op_q)
				OP_ROLL:   res_q <= a_q + mod_rem;
				OP_CHANCE: res_q <= ($signed(a_q) > $signed(mod_rem)) ? 64'd1 : 64'd0;
				default:   res_q <= mod_rem;
			endcase
		end
		if (st_q == ST_RES && out_free) begin
			out_value_q <= res_q;
		end
	end

	assign req.ready = (st_q == ST_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.value = out_value_q;

endmodule
`default_nettype wire

@@ design/xsr_checker.sv @@
// Port-level checker of the generator core and its bind.
`default_nettype none
module xsr_checker import xsr_pkg::*; (
	input wire          clk,
	input wire          arst_n,
	input wire          req_valid,
	input wire          req_ready,
	input wire [2:0]    req_opcode,
	input wire          rsp_valid,
	input wire          rsp_ready,
	input wire [63:0]   rsp_value
);

	wire req_acc = req_valid && req_ready;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
		else $error("response dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while previous one in flight");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && !rsp_valid |=> !rsp_valid)
		else $error("response appeared one cycle after request");

	a_get_state_masked: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && !rsp_valid && req_opcode == OP_GET_STATE
		|=> ##1 rsp_valid && rsp_value[63:62] == 2'b00)
		else $error("get_state response late or unmasked");

endmodule

bind xorshift64star_bounded_rng_core xsr_checker u_xsr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_opcode (req.opcode),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.value)
);
`default_nettype wire
